>>> design/calendar_date_step_macros.svh
// assertion helpers for the calendar date step block
`ifndef CALENDAR_DATE_STEP_MACROS_SVH
`define CALENDAR_DATE_STEP_MACROS_SVH

// condition holds in the same cycle as the trigger
`define CDS_ASSERT_SAME(label, trig, cond) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |-> (cond)) \
        else $error("calendar_date_step: same-cycle check failed");

// condition holds in the cycle after the trigger
`define CDS_ASSERT_NEXT(label, trig, cond) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (cond)) \
        else $error("calendar_date_step: next-cycle check failed");

`endif

>>> design/cdate_pkg.sv
package cdate_pkg;

    typedef enum logic [1:0] {
        REQ_LOAD = 2'd0,
        REQ_INC  = 2'd1,
        REQ_DEC  = 2'd2,
        REQ_NONE = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MOD,
        ST_NORM,
        ST_DONE
    } state_t;

    localparam logic [3:0] MONTH_JAN = 4'd1;
    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_DEC = 4'd12;

    localparam logic [4:0] YEAR_MOD_BASE = 5'd25;
    localparam int unsigned RESET_YEAR = 1999;

    // days in month m; out-of-range months read as december
    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        unique case (m)
            4'd2:                 len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            default:              len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

>>> design/calendar_date_step.sv
// calendar date step: load, next day or previous day, one result beat per request
// step and unused code: after accept, the normalise state carries at most one month, then the result beat
// load: for k months carried (up to about 34) the result beat comes after these steps:
// the year mod 25 state, one pass per month on the shared add unit, then a final check
// not ready until the result beat is taken; next request accepted in the cycle after
// synchronous active-low reset gives 1 january 1999
`include "calendar_date_step_macros.svh"

module calendar_date_step #(
    parameter int LOAD_DAY_BITS = 11,
    parameter int YEAR_BITS     = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [1:0]               s_req_type,
    input  logic [LOAD_DAY_BITS-1:0] s_load_day,
    input  logic [3:0]               s_load_month,
    input  logic [15:0]              s_load_year,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [4:0]               m_cur_day,
    output logic [3:0]               m_cur_month,
    output logic [15:0]              m_cur_year
);

    localparam int DW = LOAD_DAY_BITS + 1;
    // fraction width for the reciprocal of 25; five guard bits keep it exact
    localparam int FW = YEAR_BITS + 5;
    localparam int PW = FW + 5;
    localparam logic [FW-1:0] YEAR_REC =
        FW'(((64'd1 << FW) + 64'd24) / 64'd25);
    localparam logic [4:0] RESET_MOD =
        5'(cdate_pkg::RESET_YEAR % 25);
    localparam logic [4:0] YEAR_MAX_MOD =
        5'(((64'd1 << YEAR_BITS) - 64'd1) % 64'd25);
    localparam logic [YEAR_BITS-1:0] YEAR_MAX = {YEAR_BITS{1'b1}};

    cdate_pkg::state_t state_reg, state_next;
    logic signed [DW-1:0] day_reg, day_next;
    logic [3:0]           month_reg, month_next;
    logic [YEAR_BITS-1:0] year_reg, year_next;
    logic [4:0]           ymod_reg, ymod_next;
    logic [FW-1:0]        frac_reg, frac_next;

    logic                 leap;
    logic [4:0]           len_cur;
    logic [4:0]           len_prev;
    logic [3:0]           month_prev;
    logic signed [DW-1:0] len_cur_s;
    logic signed [DW-1:0] addend;
    logic signed [DW-1:0] day_sum;
    logic [PW-1:0]        mod_prod;
    logic [3:0]           load_month_clamped;
    logic                 go_up;
    logic                 go_down;
    logic                 date_ok;

    // y%100 == 0 is y%4 == 0 with y%25 == 0, y%400 likewise with y%16
    assign leap = (ymod_reg != 5'd0) ? (year_reg[1:0] == 2'd0) : (year_reg[3:0] == 4'd0);

    assign month_prev = (month_reg <= cdate_pkg::MONTH_JAN) ? cdate_pkg::MONTH_DEC
                                                             : month_reg - 4'd1;
    assign len_cur  = cdate_pkg::month_len(month_reg, leap);
    // stepping back into february never changes the year
    assign len_prev = cdate_pkg::month_len(month_prev, leap);
    assign len_cur_s = $signed({{(DW-5){1'b0}}, len_cur});

    assign go_up   = day_reg > len_cur_s;
    assign go_down = day_reg < $signed(DW'(1));

    // one shared adder for both directions of the carry
    assign addend  = go_down ? $signed({{(DW-5){1'b0}}, len_prev}) : -len_cur_s;
    assign day_sum = day_reg + addend;

    // fraction of year/25 times 25 gives the remainder in the top bits
    assign mod_prod = PW'(frac_reg) * PW'(cdate_pkg::YEAR_MOD_BASE);

    assign date_ok = (month_reg >= cdate_pkg::MONTH_JAN) && (month_reg <= cdate_pkg::MONTH_DEC)
                   && (day_reg >= $signed(DW'(1))) && (day_reg <= len_cur_s);

    always_comb begin
        if (s_load_month == 4'd0) begin
            load_month_clamped = cdate_pkg::MONTH_JAN;
        end else if (s_load_month > cdate_pkg::MONTH_DEC) begin
            load_month_clamped = cdate_pkg::MONTH_DEC;
        end else begin
            load_month_clamped = s_load_month;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cdate_pkg::ST_IDLE;
            day_reg   <= DW'(1);
            month_reg <= cdate_pkg::MONTH_JAN;
            year_reg  <= YEAR_BITS'(cdate_pkg::RESET_YEAR);
            ymod_reg  <= RESET_MOD;
            frac_reg  <= '0;
        end else begin
            state_reg <= state_next;
            day_reg   <= day_next;
            month_reg <= month_next;
            year_reg  <= year_next;
            ymod_reg  <= ymod_next;
            frac_reg  <= frac_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        day_next   = day_reg;
        month_next = month_reg;
        year_next  = year_reg;
        ymod_next  = ymod_reg;
        frac_next  = frac_reg;
        unique case (state_reg)
            cdate_pkg::ST_IDLE: begin
                if (s_valid) begin
                    unique case (cdate_pkg::req_t'(s_req_type))
                        cdate_pkg::REQ_LOAD: begin
                            day_next   = $signed({s_load_day[LOAD_DAY_BITS-1], s_load_day});
                            month_next = load_month_clamped;
                            year_next  = YEAR_BITS'(s_load_year);
                            frac_next  = {5'd0, YEAR_BITS'(s_load_year)} * YEAR_REC;
                            state_next = cdate_pkg::ST_MOD;
                        end
                        cdate_pkg::REQ_INC: begin
                            day_next   = day_reg + DW'(1);
                            state_next = cdate_pkg::ST_NORM;
                        end
                        cdate_pkg::REQ_DEC: begin
                            day_next   = day_reg - DW'(1);
                            state_next = cdate_pkg::ST_NORM;
                        end
                        default: begin
                            state_next = cdate_pkg::ST_NORM;
                        end
                    endcase
                end
            end
            cdate_pkg::ST_MOD: begin
                // remainder by 25 of the loaded year
                ymod_next  = mod_prod[PW-1:FW];
                state_next = cdate_pkg::ST_NORM;
            end
            cdate_pkg::ST_NORM: begin
                priority if (go_up) begin
                    day_next = day_sum;
                    if (month_reg >= cdate_pkg::MONTH_DEC) begin
                        month_next = cdate_pkg::MONTH_JAN;
                        year_next  = year_reg + YEAR_BITS'(1);
                        if (year_reg == YEAR_MAX) begin
                            ymod_next = '0;
                        end else begin
                            ymod_next = (ymod_reg == cdate_pkg::YEAR_MOD_BASE - 5'd1)
                                      ? 5'd0 : ymod_reg + 5'd1;
                        end
                    end else begin
                        month_next = month_reg + 4'd1;
                    end
                end else if (go_down) begin
                    day_next   = day_sum;
                    month_next = month_prev;
                    if (month_reg <= cdate_pkg::MONTH_JAN) begin
                        year_next = year_reg - YEAR_BITS'(1);
                        if (year_reg == '0) begin
                            ymod_next = YEAR_MAX_MOD;
                        end else begin
                            ymod_next = (ymod_reg == 5'd0)
                                      ? cdate_pkg::YEAR_MOD_BASE - 5'd1 : ymod_reg - 5'd1;
                        end
                    end
                end else begin
                    state_next = cdate_pkg::ST_DONE;
                end
            end
            cdate_pkg::ST_DONE: begin
                if (m_ready) begin
                    state_next = cdate_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = cdate_pkg::ST_IDLE;
            end
        endcase
    end

    assign s_ready     = (state_reg == cdate_pkg::ST_IDLE);
    assign m_valid     = (state_reg == cdate_pkg::ST_DONE);
    assign m_cur_day   = day_reg[4:0];
    assign m_cur_month = month_reg;
    assign m_cur_year  = 16'(year_reg);

    `CDS_ASSERT_SAME(a_date_range, m_valid, date_ok)
    `CDS_ASSERT_SAME(a_one_in_flight, s_valid && s_ready, !m_valid)
    `CDS_ASSERT_NEXT(a_step_to_norm, s_valid && s_ready && cdate_pkg::req_t'(s_req_type) != cdate_pkg::REQ_LOAD, state_reg == cdate_pkg::ST_NORM)

endmodule
